// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the command line assembler.
// Relies on signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CLA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");

`define CLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

`define CLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`else

`define CLA_ASSERT(lbl, expr)
`define CLA_ASSERT_IMP(lbl, ante, cons)
`define CLA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/cla_pkg.sv =====
// Shared constants and types of the command line assembler.
// No dependencies.
package cla_pkg;

  localparam int LINE_CAP_DEF = 32;
  localparam int CNT_W        = 6;

  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_ESC     = 8'd27;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_BRACKET = 8'd91;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
    logic             ovr;
  } job_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_byte;
    logic       overrun;
  } out_t;

endpackage

// ===== hw/rtl/command_line_assembler.sv =====
// Command line assembler: one received byte per cycle into a two-bank line RAM.
// A CR queues a line job for the back end; while its output buffer has room, the line
// leaves at one byte per cycle, fill + 2 beats, set by the single RAM read port.
// Throughput: one byte accepted per cycle while fewer than two lines await emission.
// Reset: synchronous, active low; clears escape state, fill count, flag and queues.
module command_line_assembler
  import cla_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_line_byte,
  output logic       out_last_byte,
  output logic       out_overrun
);

  localparam int AW = $clog2(2 * LINE_CAPACITY);

  logic          accept;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          job_push, job_pop, job_valid, done;
  job_t          job_in, job_head;
  out_t          out;
  logic [1:0]    outst_r;

  assign full   = (outst_r == 2'd2);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
    end else begin
      outst_r <= outst_r + {1'b0, job_push} - {1'b0, done};
    end
  end

  cla_front #(.LINE_CAPACITY(LINE_CAPACITY), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  cla_ram #(.WIDTH(8), .DEPTH(2 * LINE_CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cla_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (job_pop),
    .valid    (job_valid),
    .head     (job_head)
  );

  cla_back #(.LINE_CAPACITY(LINE_CAPACITY), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .empty     (empty),
    .pop       (pop),
    .out       (out)
  );

  assign out_line_byte = out.line_byte;
  assign out_last_byte = out.last_byte;
  assign out_overrun   = out.overrun;

endmodule

// ===== hw/rtl/cla_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cla_front.sv =====
// Front end: escape handling, delete, overrun and line storage.
// Uses cla_pkg and assert_macros.svh; writes the line RAM, emits line jobs.
`include "assert_macros.svh"

module cla_front
  import cla_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAP_DEF,
  parameter int AW            = $clog2(2 * LINE_CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          job_push,
  output job_t          job
);

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_SEEN = 3'b010,
    ESC_BRKT = 3'b100
  } esc_t;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(LINE_CAPACITY);
  localparam logic [AW-1:0]    BANK_OFS = AW'(LINE_CAPACITY);

  esc_t             esc_r, esc_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             ovr_r, ovr_nxt;
  logic             bank_r, bank_nxt;
  logic             is_full;
  logic [7:0]       b;
  logic             ovr_now;
  logic             drop;
  esc_t             esc_cls;

  assign is_full = (fill_r >= CAP_C);
  assign b       = is_full ? CH_CR : rx_byte;
  assign ovr_now = ovr_r | is_full;

  always_comb begin
    drop    = 1'b0;
    esc_cls = ESC_IDLE;
    case (esc_r)
      ESC_SEEN: begin
        if (b == CH_BRACKET) begin
          esc_cls = ESC_BRKT;
          drop    = 1'b1;
        end
      end
      ESC_BRKT: begin
        drop = 1'b1;
      end
      default: begin
        esc_cls = ESC_IDLE;
      end
    endcase
    if (!drop && b == CH_ESC) begin
      esc_cls = ESC_SEEN;
      drop    = 1'b1;
    end
  end

  always_comb begin
    esc_nxt   = esc_r;
    fill_nxt  = fill_r;
    ovr_nxt   = ovr_r;
    bank_nxt  = bank_r;
    ram_we    = 1'b0;
    job_push  = 1'b0;
    if (accept) begin
      esc_nxt = esc_cls;
      ovr_nxt = ovr_now;
      if (!drop && b != CH_LF) begin
        if (b == CH_CR) begin
          job_push = 1'b1;
          fill_nxt = '0;
          ovr_nxt  = 1'b0;
          bank_nxt = ~bank_r;
        end else if (b == CH_DEL) begin
          if (fill_r != '0) begin
            fill_nxt = fill_r - 1'b1;
          end
        end else begin
          ram_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
    end
  end

  assign ram_waddr = bank_r ? BANK_OFS + AW'(fill_r) : AW'(fill_r);
  assign ram_wdata = b;
  assign job.bank  = bank_r;
  assign job.len   = fill_r;
  assign job.ovr   = ovr_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= ESC_IDLE;
      fill_r <= '0;
      ovr_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      esc_r  <= esc_nxt;
      fill_r <= fill_nxt;
      ovr_r  <= ovr_nxt;
      bank_r <= bank_nxt;
    end
  end

  `CLA_ASSERT(a_fill_bound, fill_r <= CAP_C)
  `CLA_ASSERT_IMP(a_wr_room, ram_we, fill_r < CAP_C)
  `CLA_ASSERT_NXT(a_push_clears, job_push, fill_r == '0 && !ovr_r)

endmodule

// ===== hw/rtl/cla_queue.sv =====
// Two-entry job queue between the front end and the line emitter.
// Uses cla_pkg for the job type.
module cla_queue
  import cla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign valid = (cnt_r != '0);
  assign head  = slot_r[rp_r];

endmodule

// ===== hw/rtl/cla_back.sv =====
// Back end: reads a stored line from RAM and emits it with CR and LF.
// Uses cla_pkg and assert_macros.svh; holds a four-entry result buffer.
`include "assert_macros.svh"

module cla_back
  import cla_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAP_DEF,
  parameter int AW            = $clog2(2 * LINE_CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  job_t          job,
  output logic          job_pop,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          done,
  output logic          empty,
  input  logic          pop,
  output out_t          out
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  localparam logic [AW-1:0] BANK_OFS = AW'(LINE_CAPACITY);

  bstate_t          st_r, st_nxt;
  job_t             cur_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             issue;
  logic             at_cr, at_lf;

  logic             p1_v_r;
  logic             p1_ram_r;
  out_t             p1_r, p1_nxt;

  out_t             obuf_r [4];
  logic [1:0]       owp_r, orp_r;
  logic [2:0]       ocnt_r;
  logic             owr;
  logic             ord;
  out_t             owdata;

  assign at_cr = (idx_r == cur_r.len);
  assign at_lf = ({1'b0, idx_r} == {1'b0, cur_r.len} + 1'b1);
  assign issue = (st_r == B_RUN) && ((ocnt_r + {2'b0, p1_v_r}) < 3'd4);

  assign job_pop   = (st_r == B_IDLE) && job_valid;
  assign ram_re    = issue && !at_cr && !at_lf;
  assign ram_raddr = cur_r.bank ? BANK_OFS + AW'(idx_r) : AW'(idx_r);
  assign done      = issue && at_lf;

  always_comb begin
    st_nxt             = st_r;
    idx_nxt            = idx_r;
    p1_nxt.line_byte   = at_lf ? CH_LF : CH_CR;
    p1_nxt.last_byte   = at_lf;
    p1_nxt.overrun     = cur_r.ovr;
    case (st_r)
      B_IDLE: begin
        if (job_valid) begin
          st_nxt  = B_RUN;
          idx_nxt = '0;
        end
      end
      B_RUN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
          if (at_lf) begin
            st_nxt = B_IDLE;
          end
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      p1_v_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      p1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (job_pop) begin
      cur_r <= job;
    end
    if (issue) begin
      p1_r     <= p1_nxt;
      p1_ram_r <= ram_re;
    end
  end

  assign owr = p1_v_r;
  assign ord = pop && !empty;
  always_comb begin
    owdata = p1_r;
    if (p1_ram_r) begin
      owdata.line_byte = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (owr) begin
      obuf_r[owp_r] <= owdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (owr) begin
        owp_r <= owp_r + 1'b1;
      end
      if (ord) begin
        orp_r <= orp_r + 1'b1;
      end
      ocnt_r <= ocnt_r + {2'b0, owr} - {2'b0, ord};
    end
  end

  assign empty = (ocnt_r == '0);
  assign out   = obuf_r[orp_r];

  `CLA_ASSERT(a_obuf_bound, ocnt_r <= 3'd4)
  `CLA_ASSERT_IMP(a_last_is_lf, !empty && out.last_byte, out.line_byte == CH_LF)
  `CLA_ASSERT_NXT(a_done_idle, done, st_r == B_IDLE)

endmodule

// ===== tb/command_line_assembler_test.sv =====
// Self-checking testbench for command_line_assembler: directed table, then random lines.
// Depends on cla_pkg and the command_line_assembler RTL; reads no files.
module command_line_assembler_test
  import cla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CAP     = LINE_CAP_DEF;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 50;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_SEEN = 3'b010,
    ESC_CSI  = 3'b100
  } esc_phase_t;

  typedef struct {
    bit chk;
    int len;
    bit ovr;
  } line_check_t;

  typedef struct {
    logic [7:0] ch;
    int         reps;
    bit         chk;
    int         len;
    bit         ovr;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_line_byte;
  logic       out_last_byte;
  logic       out_overrun;

  // line assembly state
  esc_phase_t  esc_state = ESC_IDLE;
  logic [7:0]  line_buf [LINE_CAP];
  int          line_fill = 0;
  bit          ovr_pending = 1'b0;
  out_t        line_beats_due [$];
  line_check_t line_checks [$];
  line_check_t row_check = '{0, 0, 0};

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit long_hold_req = 1'b0;

  int mismatches = 0;
  int items_sent = 0;
  int bytes_in = 0;
  int beats_out = 0;
  int lines_out = 0;
  int overrun_lines = 0;
  int dut_line_beats = 0;
  int cycle_count = 0;

  stim_row_t dir_rows [26] = '{
    '{CH_DEL,     1,  0, 0,  0},
    '{CH_CR,      1,  1, 2,  0},
    '{8'h00,      1,  0, 0,  0},
    '{8'hFF,      1,  0, 0,  0},
    '{CH_LF,      1,  0, 0,  0},
    '{"Q",        1,  0, 0,  0},
    '{CH_DEL,     1,  0, 0,  0},
    '{CH_CR,      1,  1, 4,  0},
    '{CH_ESC,     1,  0, 0,  0},
    '{CH_BRACKET, 1,  0, 0,  0},
    '{CH_CR,      1,  0, 0,  0},
    '{"A",        1,  0, 0,  0},
    '{CH_ESC,     1,  0, 0,  0},
    '{"B",        1,  0, 0,  0},
    '{CH_ESC,     1,  0, 0,  0},
    '{CH_BRACKET, 1,  0, 0,  0},
    '{CH_ESC,     1,  0, 0,  0},
    '{CH_ESC,     1,  0, 0,  0},
    '{CH_CR,      1,  1, 4,  0},
    '{"w",        31, 0, 0,  0},
    '{CH_CR,      1,  1, 33, 0},
    '{"z",        32, 0, 0,  0},
    '{"k",        1,  1, 34, 1},
    '{CH_CR,      1,  1, 2,  0},
    '{"y",        32, 0, 0,  0},
    '{CH_ESC,     1,  1, 34, 1}
  };

  command_line_assembler #(.LINE_CAPACITY(LINE_CAP)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_rx_byte    (in_rx_byte),
    .empty         (empty),
    .pop           (pop),
    .out_line_byte (out_line_byte),
    .out_last_byte (out_last_byte),
    .out_overrun   (out_overrun)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Folds one accepted byte into the line state; a CR queues the whole line.
  task automatic assemble_byte(input logic [7:0] rx);
    logic [7:0] c;
    bit         swallow;
    c = rx;
    swallow = 1'b0;
    if (line_fill >= LINE_CAP) begin
      c = CH_CR;
      ovr_pending = 1'b1;
    end
    case (esc_state)
      ESC_SEEN: begin
        if (c == CH_BRACKET) begin
          esc_state = ESC_CSI;
          swallow = 1'b1;
        end else begin
          esc_state = ESC_IDLE;
        end
      end
      ESC_CSI: begin
        esc_state = ESC_IDLE;
        swallow = 1'b1;
      end
      default: esc_state = ESC_IDLE;
    endcase
    if (!swallow && c == CH_ESC) begin
      esc_state = ESC_SEEN;
      swallow = 1'b1;
    end
    if (swallow || c == CH_LF) return;
    if (c == CH_CR) begin
      for (int i = 0; i < line_fill; i++)
        line_beats_due.push_back('{line_buf[i], 1'b0, ovr_pending});
      line_beats_due.push_back('{CH_CR, 1'b0, ovr_pending});
      line_beats_due.push_back('{CH_LF, 1'b1, ovr_pending});
      line_checks.push_back(row_check);
      if (ovr_pending) overrun_lines++;
      line_fill = 0;
      ovr_pending = 1'b0;
    end else if (c == CH_DEL) begin
      if (line_fill > 0) line_fill--;
    end else if (line_fill < LINE_CAP) begin
      line_buf[line_fill] = c;
      line_fill++;
    end
  endtask

  always @(posedge clk) begin
    out_t        want;
    line_check_t lc;
    if (rst_n) begin
      if (push && !full) begin
        bytes_in++;
        assemble_byte(in_rx_byte);
      end
      if (pop && !empty) begin
        beats_out++;
        dut_line_beats++;
        if (line_beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte=%h last=%b ovr=%b",
                                    out_line_byte, out_last_byte, out_overrun));
        end else begin
          want = line_beats_due.pop_front();
          if (out_line_byte !== want.line_byte)
            report_mismatch($sformatf("line_byte %h, want %h", out_line_byte, want.line_byte));
          if (out_last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %b, want %b", out_last_byte, want.last_byte));
          if (out_overrun !== want.overrun)
            report_mismatch($sformatf("overrun %b, want %b", out_overrun, want.overrun));
        end
        if (out_last_byte === 1'b1) begin
          lines_out++;
          if (line_checks.size() > 0) begin
            lc = line_checks.pop_front();
            if (lc.chk && (dut_line_beats != lc.len || out_overrun !== lc.ovr))
              report_mismatch($sformatf("line of %0d beats ovr=%b, table says %0d ovr=%b",
                                        dut_line_beats, out_overrun, lc.len, lc.ovr));
          end
          dut_line_beats = 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      report_mismatch($sformatf("timeout, %0d beats still due", line_beats_due.size()));
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receive side: random pop bursts plus one long hold on request.
  initial begin : drain_side
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        stall_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] ch, input bit chk = 0, input int len = 0,
                           input bit ovr = 0);
    if (tx_idle && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= ch;
    row_check = '{chk, len, ovr};
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (ch != CH_LF) items_sent++;
  endtask

  function automatic logic [7:0] pick_line_char();
    case ($urandom_range(0, 15))
      0:       return CH_DEL;
      1:       return CH_LF;
      2:       return CH_ESC;
      3:       return CH_BRACKET;
      4:       return CH_CR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_line(input int max_len);
    int n;
    if ($urandom_range(0, 11) == 0) n = $urandom_range(24, LINE_CAP + 8);
    else n = $urandom_range(0, max_len);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_byte(CH_ESC);
        send_byte(CH_BRACKET);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(pick_line_char());
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(CH_CR);
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r])
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_byte(dir_rows[r].ch, dir_rows[r].chk && k == dir_rows[r].reps - 1,
                  dir_rows[r].len, dir_rows[r].ovr);

    while (items_sent < 150) send_random_line(8);

    // hold the output long enough for the block to back up and raise full
    long_hold_req = 1'b1;
    repeat (4) begin
      send_byte(8'($urandom_range(32, 126)));
      send_byte(CH_CR);
    end

    push <= 1'b0;
    while (line_beats_due.size() != 0) @(negedge clk);

    while (items_sent < 230) send_random_line(8);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (items_sent < 280) send_random_line(8);

    push <= 1'b0;
    while (line_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run fed %0d bytes and took %0d line beats in %0d lines (%0d cut by overrun),",
             bytes_in, beats_out, lines_out, overrun_lines);
    $display("with escapes, deletes, full-line overruns, a long output hold and idle gaps.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
